>>> rtl/first_fit_heap_allocator_assert.svh
// assertion macros shared by the heap allocator modules
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// condition implies consequence in the same cycle
`define FFHA_ASSERT_NOW(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

// condition implies consequence in the next cycle
`define FFHA_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/ffha_pkg.sv
// package for the first-fit heap allocator: types, codes and constants
`timescale 1ns / 1ps
package ffha_pkg;

   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int HEADER_BYTES_DEF = 16;
   localparam int ALIGN_BYTES      = 8;
   localparam int OFS_W            = 21;
   localparam int NEED_W           = 22;
   localparam int ADDR_W           = 32;

   localparam logic [ADDR_W-1:0] HEAP_BASE_RST  = 32'h0030_0000;
   localparam logic [OFS_W-1:0]  HEAP_BYTES_RST = 21'h10_0000;

   localparam logic [1:0] ACT_INIT  = 2'd0;
   localparam logic [1:0] ACT_ALLOC = 2'd1;
   localparam logic [1:0] ACT_FREE  = 2'd2;

   localparam logic CSR_HEAP_BASE  = 1'b0;
   localparam logic CSR_HEAP_BYTES = 1'b1;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOTHING = 2'd1,
      ST_NOMEM   = 2'd2,
      ST_BADPTR  = 2'd3
   } status_type;

   typedef struct packed {
      logic [OFS_W-1:0] ofs;
      logic [OFS_W-1:0] pay;
      logic             free;
   } seg_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_INIT,
      CMD_RES_NOTHING,
      CMD_RES_NOMEM,
      CMD_RES_BADPTR,
      CMD_SCAN_RD,
      CMD_NEXT,
      CMD_ALLOC_TAKE,
      CMD_SPLIT_PREP,
      CMD_SHIFT_RD,
      CMD_SHIFT_WR,
      CMD_SPLIT_TAIL,
      CMD_SPLIT_HEAD,
      CMD_FREE_MARK,
      CMD_MRG_START,
      CMD_MRG_LOAD,
      CMD_MRG_RD,
      CMD_MRG_STEP,
      CMD_MRG_END,
      CMD_PUBLISH
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       zero_req;
      logic       null_addr;
      logic       scan_end;
      logic       fit;
      logic       split_ok;
      logic       match;
      logic       shift_done;
      logic       mrg_end;
      logic       out_free;
   } dp_status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_ASCAN_RD,
      S_ASCAN_CHK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_SPLIT_TAIL,
      S_SPLIT_HEAD,
      S_FSCAN_RD,
      S_FSCAN_CHK,
      S_MRG_START,
      S_MRG_LOAD,
      S_MRG_RD,
      S_MRG_CHK,
      S_MRG_END,
      S_RESP
   } state_type;

endpackage

>>> rtl/ffha_datapath.sv
// segment table memory, counters, arithmetic and result register
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_assert.svh"
module ffha_datapath
   import ffha_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output dp_status_type       dp_status,
   input  logic [1:0]          req_action,
   input  logic [OFS_W-1:0]    req_request_bytes,
   input  logic [ADDR_W-1:0]   req_block_address,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [ADDR_W-1:0]   csr_write_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [ADDR_W-1:0]   rsp_granted_address
);

   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam logic [OFS_W-1:0]  HDR      = OFS_W'(HEADER_BYTES);
   localparam logic [CW-1:0]     MAX_CNT  = CW'(MAX_SEGMENTS);
   localparam logic [NEED_W-1:0] ALN_MASK = ~NEED_W'(ALIGN_BYTES - 1);

   seg_type mem [MAX_SEGMENTS];
   seg_type rdata_ff;
   logic              rd_en;
   logic [IW-1:0]     rd_addr;
   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   seg_type           wr_data;

   logic [ADDR_W-1:0] heap_base_ff;
   logic [OFS_W-1:0]  heap_bytes_ff;
   logic [1:0]        action_ff;
   logic [NEED_W-1:0] need_ff, need_in;
   logic              zero_req_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     i_ff, i_in;
   logic [CW-1:0]     k_ff, k_in;
   logic [CW-1:0]     j_ff, j_in;
   logic [CW-1:0]     w_ff, w_in;
   seg_type           acc_ff, acc_in;
   status_type        res_status_ff, res_status_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;

   logic [ADDR_W-1:0] rd_payload_addr;
   logic [ADDR_W-1:0] acc_payload_addr;
   logic [NEED_W:0]   split_need;
   logic [OFS_W-1:0]  init_pay;

   assign need_in = (NEED_W'(req_request_bytes) + NEED_W'(ALIGN_BYTES - 1)) & ALN_MASK;
   assign rd_payload_addr  = heap_base_ff + ADDR_W'(rdata_ff.ofs) + ADDR_W'(HEADER_BYTES);
   assign acc_payload_addr = heap_base_ff + ADDR_W'(acc_ff.ofs) + ADDR_W'(HEADER_BYTES);
   assign split_need = {1'b0, need_ff} + (NEED_W + 1)'(HEADER_BYTES + ALIGN_BYTES);
   assign init_pay = (heap_bytes_ff > HDR) ? heap_bytes_ff - HDR : '0;

   always_comb begin
      dp_status.action     = action_ff;
      dp_status.zero_req   = zero_req_ff;
      dp_status.null_addr  = (addr_ff == '0);
      dp_status.scan_end   = (i_ff >= count_ff);
      dp_status.fit        = rdata_ff.free && ({1'b0, rdata_ff.pay} >= need_ff);
      dp_status.split_ok   = ({2'b0, rdata_ff.pay} >= split_need) && (count_ff < MAX_CNT);
      dp_status.match      = (rd_payload_addr == addr_ff);
      dp_status.shift_done = (k_ff == i_ff + CW'(1));
      dp_status.mrg_end    = (j_ff >= count_ff);
      dp_status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // memory port control and register next values
   always_comb begin
      rd_en         = 1'b0;
      rd_addr       = i_ff[IW-1:0];
      wr_en         = 1'b0;
      wr_addr       = i_ff[IW-1:0];
      wr_data       = rdata_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      k_in          = k_ff;
      j_in          = j_ff;
      w_in          = w_ff;
      acc_in        = acc_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      case (cmd)
         CMD_LOAD: begin
            i_in = '0;
         end
         CMD_INIT: begin
            wr_en         = 1'b1;
            wr_addr       = '0;
            wr_data.ofs   = '0;
            wr_data.pay   = init_pay;
            wr_data.free  = 1'b1;
            count_in      = CW'(1);
            res_status_in = ST_OK;
            res_addr_in   = '0;
         end
         CMD_RES_NOTHING: begin
            res_status_in = ST_NOTHING;
            res_addr_in   = '0;
         end
         CMD_RES_NOMEM: begin
            res_status_in = ST_NOMEM;
            res_addr_in   = '0;
         end
         CMD_RES_BADPTR: begin
            res_status_in = ST_BADPTR;
            res_addr_in   = '0;
         end
         CMD_SCAN_RD: begin
            rd_en = 1'b1;
         end
         CMD_NEXT: begin
            i_in = i_ff + CW'(1);
         end
         CMD_ALLOC_TAKE: begin
            wr_en         = 1'b1;
            wr_data.free  = 1'b0;
            res_status_in = ST_OK;
            res_addr_in   = rd_payload_addr;
         end
         CMD_SPLIT_PREP: begin
            acc_in = rdata_ff;
            k_in   = count_ff;
         end
         CMD_SHIFT_RD: begin
            rd_en   = 1'b1;
            rd_addr = IW'(k_ff - CW'(1));
         end
         CMD_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = k_ff[IW-1:0];
            k_in    = k_ff - CW'(1);
         end
         CMD_SPLIT_TAIL: begin
            wr_en        = 1'b1;
            wr_addr      = IW'(i_ff + CW'(1));
            wr_data.ofs  = acc_ff.ofs + HDR + need_ff[OFS_W-1:0];
            wr_data.pay  = acc_ff.pay - need_ff[OFS_W-1:0] - HDR;
            wr_data.free = 1'b1;
         end
         CMD_SPLIT_HEAD: begin
            wr_en         = 1'b1;
            wr_data.ofs   = acc_ff.ofs;
            wr_data.pay   = need_ff[OFS_W-1:0];
            wr_data.free  = 1'b0;
            count_in      = count_ff + CW'(1);
            res_status_in = ST_OK;
            res_addr_in   = acc_payload_addr;
         end
         CMD_FREE_MARK: begin
            wr_en        = 1'b1;
            wr_data.free = 1'b1;
         end
         CMD_MRG_START: begin
            rd_en   = 1'b1;
            rd_addr = '0;
            j_in    = CW'(1);
            w_in    = '0;
         end
         CMD_MRG_LOAD: begin
            acc_in = rdata_ff;
         end
         CMD_MRG_RD: begin
            rd_en   = 1'b1;
            rd_addr = j_ff[IW-1:0];
         end
         CMD_MRG_STEP: begin
            // free runs fold into the accumulated entry
            if (acc_ff.free && rdata_ff.free) begin
               acc_in.pay = acc_ff.pay + HDR + rdata_ff.pay;
            end else begin
               wr_en   = 1'b1;
               wr_addr = w_ff[IW-1:0];
               wr_data = acc_ff;
               w_in    = w_ff + CW'(1);
               acc_in  = rdata_ff;
            end
            j_in = j_ff + CW'(1);
         end
         CMD_MRG_END: begin
            wr_en         = 1'b1;
            wr_addr       = w_ff[IW-1:0];
            wr_data       = acc_ff;
            count_in      = w_ff + CW'(1);
            res_status_in = ST_OK;
            res_addr_in   = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff  <= HEAP_BASE_RST;
         heap_bytes_ff <= HEAP_BYTES_RST;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable && csr_index == CSR_HEAP_BASE) begin
            heap_base_ff <= csr_write_data;
         end
         if (csr_write_enable && csr_index == CSR_HEAP_BYTES) begin
            heap_bytes_ff <= csr_write_data[OFS_W-1:0];
         end
         count_ff <= count_in;
         if (cmd == CMD_PUBLISH) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd == CMD_LOAD) begin
         action_ff   <= req_action;
         need_ff     <= need_in;
         zero_req_ff <= (req_request_bytes == '0);
         addr_ff     <= req_block_address;
      end
      if (cmd == CMD_PUBLISH) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_addr_ff;
      end
      i_ff          <= i_in;
      k_ff          <= k_in;
      j_ff          <= j_in;
      w_ff          <= w_in;
      acc_ff        <= acc_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_addr_ff;

   `FFHA_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= MAX_CNT)
   `FFHA_ASSERT_NOW(a_split_room, clock, reset, cmd == CMD_SPLIT_HEAD, count_ff < MAX_CNT)
   `FFHA_ASSERT_NOW(a_publish_slot, clock, reset, cmd == CMD_PUBLISH, dp_status.out_free)
   `FFHA_ASSERT_NEXT(a_publish_valid, clock, reset, cmd == CMD_PUBLISH, rsp_valid_ff)

endmodule

>>> rtl/ffha_ctrl.sv
// controller state machine sequencing table scans, splits and merges
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_assert.svh"
module ffha_ctrl
   import ffha_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type dp_status,
   output cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:       if (req_valid) state_in = S_DECODE;
         S_DECODE: begin
            case (dp_status.action)
               ACT_INIT:  state_in = S_RESP;
               ACT_ALLOC: state_in = dp_status.zero_req ? S_RESP : S_ASCAN_RD;
               ACT_FREE:  state_in = dp_status.null_addr ? S_RESP : S_FSCAN_RD;
               default:   state_in = S_RESP;
            endcase
         end
         S_ASCAN_RD:   state_in = dp_status.scan_end ? S_RESP : S_ASCAN_CHK;
         S_ASCAN_CHK: begin
            if (dp_status.fit && dp_status.split_ok) state_in = S_SHIFT_RD;
            else if (dp_status.fit)                  state_in = S_RESP;
            else                                     state_in = S_ASCAN_RD;
         end
         S_SHIFT_RD:   state_in = dp_status.shift_done ? S_SPLIT_TAIL : S_SHIFT_WR;
         S_SHIFT_WR:   state_in = S_SHIFT_RD;
         S_SPLIT_TAIL: state_in = S_SPLIT_HEAD;
         S_SPLIT_HEAD: state_in = S_RESP;
         S_FSCAN_RD:   state_in = dp_status.scan_end ? S_RESP : S_FSCAN_CHK;
         S_FSCAN_CHK:  state_in = dp_status.match ? S_MRG_START : S_FSCAN_RD;
         S_MRG_START:  state_in = S_MRG_LOAD;
         S_MRG_LOAD:   state_in = S_MRG_RD;
         S_MRG_RD:     state_in = dp_status.mrg_end ? S_MRG_END : S_MRG_CHK;
         S_MRG_CHK:    state_in = S_MRG_RD;
         S_MRG_END:    state_in = S_RESP;
         S_RESP:       if (dp_status.out_free) state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = CMD_NONE;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE:       if (req_valid) cmd = CMD_LOAD;
         S_DECODE: begin
            case (dp_status.action)
               ACT_INIT:  cmd = CMD_INIT;
               ACT_ALLOC: if (dp_status.zero_req) cmd = CMD_RES_NOTHING;
               ACT_FREE:  if (dp_status.null_addr) cmd = CMD_RES_NOTHING;
               default:   cmd = CMD_RES_NOTHING;
            endcase
         end
         S_ASCAN_RD:   cmd = dp_status.scan_end ? CMD_RES_NOMEM : CMD_SCAN_RD;
         S_ASCAN_CHK: begin
            if (dp_status.fit && dp_status.split_ok) cmd = CMD_SPLIT_PREP;
            else if (dp_status.fit)                  cmd = CMD_ALLOC_TAKE;
            else                                     cmd = CMD_NEXT;
         end
         S_SHIFT_RD:   if (!dp_status.shift_done) cmd = CMD_SHIFT_RD;
         S_SHIFT_WR:   cmd = CMD_SHIFT_WR;
         S_SPLIT_TAIL: cmd = CMD_SPLIT_TAIL;
         S_SPLIT_HEAD: cmd = CMD_SPLIT_HEAD;
         S_FSCAN_RD:   cmd = dp_status.scan_end ? CMD_RES_BADPTR : CMD_SCAN_RD;
         S_FSCAN_CHK:  cmd = dp_status.match ? CMD_FREE_MARK : CMD_NEXT;
         S_MRG_START:  cmd = CMD_MRG_START;
         S_MRG_LOAD:   cmd = CMD_MRG_LOAD;
         S_MRG_RD:     if (!dp_status.mrg_end) cmd = CMD_MRG_RD;
         S_MRG_CHK:    cmd = CMD_MRG_STEP;
         S_MRG_END:    cmd = CMD_MRG_END;
         S_RESP:       if (dp_status.out_free) cmd = CMD_PUBLISH;
         default:      cmd = CMD_NONE;
      endcase
   end

   `FFHA_ASSERT_NEXT(a_load_decode, clock, reset, cmd == CMD_LOAD, state_ff == S_DECODE)
   `FFHA_ASSERT_NOW(a_busy_stall, clock, reset, state_ff != S_IDLE, req_stall)
   `FFHA_ASSERT_NEXT(a_publish_idle, clock, reset, cmd == CMD_PUBLISH, state_ff == S_IDLE)

endmodule

>>> rtl/first_fit_heap_allocator.sv
// Usage: first-fit heap allocator over an address-ordered segment table.
// Request channel (req_valid / req_stall): action, request_bytes and
// block_address; a transaction is taken only while the block is idle.
// Response channel (rsp_valid / rsp_stall): status and granted_address, one
// response per request, held in an output register while rsp_stall is high.
// Configuration: csr_write_enable with csr_index 0 (heap_base) or 1
// (heap_bytes), to be written only while idle; the block does not enforce it.
// Operation: init and trivial requests go straight to the response.
// Allocate scans the segments in order, then on a split shifts the later
// table entries up and writes the tail and head entries. Free scans the
// segments, then runs a merge pass over every table entry.
// The segment table has one read and one write port, but only one entry
// is read or written per step.
// Reset: the table is empty (a nonzero allocate gives out of memory, a
// non-null free gives bad pointer); heap_base and heap_bytes take their defaults.
// A stalled response holds the next result back in the final state; the
// request side then stays stalled until it can be delivered.
`timescale 1ns / 1ps
module first_fit_heap_allocator
   import ffha_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_action,
   input  logic [OFS_W-1:0]  req_request_bytes,
   input  logic [ADDR_W-1:0] req_block_address,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [ADDR_W-1:0] rsp_granted_address,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [ADDR_W-1:0] csr_write_data
);

   cmd_type       cmd;
   dp_status_type dp_status;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   ffha_datapath #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .dp_status           (dp_status),
      .req_action          (req_action),
      .req_request_bytes   (req_request_bytes),
      .req_block_address   (req_block_address),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address)
   );

endmodule
